@@ design/ipv4hv_pkg.sv @@
// Package for the IPv4 header validator: verdict codes, result record and
// fixed header constants. No dependencies.
`timescale 1ns / 1ps

package ipv4hv_pkg;

  typedef enum logic [2:0] {
    StAccept   = 3'd0,
    StTtl      = 3'd1,
    StVersion  = 3'd2,
    StHdrLen   = 3'd3,
    StDest     = 3'd4,
    StChecksum = 3'd5,
    StShort    = 3'd6
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [15:0] packet_bytes;
  } verdict_t;

  localparam int          MinHeaderBytes = 20;
  localparam int          TtlPos         = 8;
  localparam int          DestFirstPos   = 16;
  localparam int          DestLastPos    = 19;
  localparam logic [3:0]  IpVersion      = 4'd4;
  localparam logic [3:0]  MinHeaderWords = 4'd5;
  localparam logic [31:0] BroadcastAddr  = 32'hFFFF_FFFF;
  localparam logic [15:0] SumGood        = 16'hFFFF;

endpackage

@@ design/ipv4hv_parse.sv @@
// Per-packet header capture, one's-complement header sum and verdict logic.
// Depends on ipv4hv_pkg.
`timescale 1ns / 1ps

module ipv4hv_parse #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [31:0]         local_address_i,
  input  logic                in_fire_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  output ipv4hv_pkg::verdict_t verdict_o
);
  import ipv4hv_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

  logic [COUNT_WIDTH-1:0] pos_q, pos_d, count;
  logic [3:0]             ver_q, ver_d, hw_q, hw_d;
  logic [7:0]             ttl_q, ttl_d, hold_q, hold_d;
  logic [31:0]            dst_q, dst_d;
  logic [15:0]            sum_q, sum_d, fold;
  logic [16:0]            raw_sum;
  logic [5:0]             hdr_bytes, need;
  logic                   in_hdr;
  status_e                status;

  always_comb begin
    ver_d  = (pos_q == '0) ? data_byte_i[7:4] : ver_q;
    hw_d   = (pos_q == '0) ? data_byte_i[3:0] : hw_q;
    ttl_d  = (pos_q == COUNT_WIDTH'(TtlPos)) ? data_byte_i : ttl_q;
    dst_d  = (pos_q >= COUNT_WIDTH'(DestFirstPos) && pos_q <= COUNT_WIDTH'(DestLastPos)) ?
             {dst_q[23:0], data_byte_i} : dst_q;
    hold_d = pos_q[0] ? hold_q : data_byte_i;

    // Odd positions complete a 16-bit word; only words inside the header count.
    hdr_bytes = {hw_d, 2'b00};
    in_hdr    = pos_q < COUNT_WIDTH'(hdr_bytes);
    raw_sum   = {1'b0, sum_q} + {1'b0, hold_q, data_byte_i};
    fold      = raw_sum[15:0] + 16'(raw_sum[16]);
    sum_d     = (pos_q[0] && in_hdr) ? fold : sum_q;

    count = (pos_q == CountMax) ? pos_q : pos_q + 1'b1;
    pos_d = count;
    need  = (hdr_bytes < 6'(MinHeaderBytes)) ? 6'(MinHeaderBytes) : hdr_bytes;

    if (count < COUNT_WIDTH'(need)) begin
      status = StShort;
    end else if (ttl_d == 8'd0) begin
      status = StTtl;
    end else if (ver_d != IpVersion) begin
      status = StVersion;
    end else if (hw_d < MinHeaderWords) begin
      status = StHdrLen;
    end else if (dst_d != local_address_i && dst_d != BroadcastAddr) begin
      status = StDest;
    end else if (sum_d != SumGood) begin
      status = StChecksum;
    end else begin
      status = StAccept;
    end

    verdict_o.status       = status;
    verdict_o.packet_bytes = 16'(count);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      ver_q  <= '0;
      hw_q   <= '0;
      ttl_q  <= '0;
      dst_q  <= '0;
      sum_q  <= '0;
      hold_q <= '0;
    end else if (in_fire_i) begin
      if (last_byte_i) begin
        pos_q  <= '0;
        ver_q  <= '0;
        hw_q   <= '0;
        ttl_q  <= '0;
        dst_q  <= '0;
        sum_q  <= '0;
        hold_q <= '0;
      end else begin
        pos_q  <= pos_d;
        ver_q  <= ver_d;
        hw_q   <= hw_d;
        ttl_q  <= ttl_d;
        dst_q  <= dst_d;
        sum_q  <= sum_d;
        hold_q <= hold_d;
      end
    end
  end

  // A finished packet leaves no trace for the next one.
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire_i && last_byte_i) |=> (pos_q == '0 && sum_q == '0))
    else $error("packet state not cleared after last byte");

  // The position only moves on an accepted byte.
  a_pos_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire_i |=> $stable(pos_q))
    else $error("byte position moved without an accepted byte");

endmodule

@@ design/ipv4_header_validator_unit.sv @@
// Top level of the IPv4 header validator: configuration register, byte
// stream input and verdict output register. Depends on ipv4hv_pkg and
// ipv4hv_parse.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata[7:0] data_byte, tlast last_byte
//   m_axis    out        tdata[2:0] status, [18:3] packet_bytes, [23:19] zero
//   cfg       in         cfg_data_i[31:0] local_address
//
// One byte is taken per cycle unless a verdict stalls; the header sum and
// field capture finish in the cycle the byte is accepted, and the registered
// verdict appears in the cycle after the last byte. Reset clears the packet
// state, the local address and the output valid. A stalled verdict blocks
// new bytes only until the cycle in which it is taken.
`timescale 1ns / 1ps

module ipv4_header_validator_unit #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,     // local_address
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [2:0] status, [18:3] packet_bytes
);
  import ipv4hv_pkg::*;

  logic [31:0] local_addr_q;
  logic        m_valid_q;
  verdict_t    res_q, verdict;
  logic        s_fire;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  ipv4hv_parse #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .local_address_i(local_addr_q),
    .in_fire_i      (s_fire),
    .data_byte_i    (s_axis_tdata),
    .last_byte_i    (s_axis_tlast),
    .verdict_o      (verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q <= '0;
    end else if (cfg_valid_i) begin
      local_addr_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s_fire && s_axis_tlast) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire && s_axis_tlast) begin
      res_q <= verdict;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'd0, res_q.packet_bytes, res_q.status};

  a_verdict_follows_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_axis_tlast) |=> m_valid_q)
    else $error("last byte accepted without a verdict");

  a_verdict_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(s_fire && s_axis_tlast))
    else $error("verdict raised without a last byte");

  a_accept_long_enough: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && res_q.status == StAccept) |->
      res_q.packet_bytes >= 16'(MinHeaderBytes))
    else $error("short packet accepted");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> res_q.packet_bytes != 16'd0)
    else $error("verdict with zero byte count");

endmodule

@@ verif/tb_ipv4_header_validator_unit.sv @@
// Self-checking testbench for ipv4_header_validator_unit: byte-stream packets in, one
// verdict per packet out, each checked against a behavioral predictor of the header checks.
// Depends on ipv4hv_pkg and the design sources of the validator.
`timescale 1ns / 1ps

module tb_ipv4_header_validator_unit;
  import ipv4hv_pkg::*;

  localparam int CountWidth = 16;
  localparam int CountMax   = (1 << CountWidth) - 1;
  localparam int StuckLimit = 2000;
  localparam int HoldCycles = 300;
  localparam int MaxReports = 10;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;  // [7:0] data_byte
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [2:0] status, [18:3] packet_bytes

  ipv4_header_validator_unit #(
    .COUNT_WIDTH(CountWidth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // Bytes waiting to be sent, {last, data}, and verdicts owed by the block.
  logic [8:0] bytes_to_send [$];
  verdict_t   verdicts_due [$];

  logic        quiet = 1'b0;
  int          fail_count = 0;
  int          verdicts_seen = 0;
  int          holdoff_left = 0;
  int          stuck_cycles = 0;
  int          bytes_queued = 0;

  // Predicted state of the header parser and the local address register.
  logic [31:0] local_addr_q = '0;
  int          pos_q = 0;
  logic [3:0]  ver_q = '0;
  logic [3:0]  ihl_q = '0;
  logic [7:0]  ttl_q = '0;
  logic [31:0] dst_q = '0;
  logic [15:0] sum_q = '0;
  logic [7:0]  hold_q = '0;

  function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  function automatic bit absorb_byte(input logic [7:0] b, input logic last,
                                     output verdict_t v);
    int      count;
    int      need;
    status_e st;
    if (pos_q == 0) begin
      ver_q = b[7:4];
      ihl_q = b[3:0];
    end
    if (pos_q == TtlPos) ttl_q = b;
    if (pos_q >= DestFirstPos && pos_q <= DestLastPos) dst_q = {dst_q[23:0], b};
    if (pos_q % 2 == 0) begin
      hold_q = b;
    end else if (pos_q < 4 * int'(ihl_q)) begin
      sum_q = fold_add(sum_q, {hold_q, b});
    end
    count = (pos_q >= CountMax) ? CountMax : pos_q + 1;
    v = '0;
    if (!last) begin
      pos_q = count;
      return 1'b0;
    end
    need = 4 * int'(ihl_q);
    if (need < MinHeaderBytes) need = MinHeaderBytes;
    if (count < need) st = StShort;
    else if (ttl_q == 8'd0) st = StTtl;
    else if (ver_q != IpVersion) st = StVersion;
    else if (ihl_q < MinHeaderWords) st = StHdrLen;
    else if (dst_q != local_addr_q && dst_q != BroadcastAddr) st = StDest;
    else if (sum_q != SumGood) st = StChecksum;
    else st = StAccept;
    v.status       = st;
    v.packet_bytes = 16'(count);
    pos_q  = 0;
    ver_q  = '0;
    ihl_q  = '0;
    ttl_q  = '0;
    dst_q  = '0;
    sum_q  = '0;
    hold_q = '0;
    return 1'b1;
  endfunction

  task automatic flag_error(input string msg);
    fail_count++;
    if (fail_count <= MaxReports) $display("ERROR: %s", msg);
  endtask

  // Builds a header with a correct checksum, then optionally spoils the checksum
  // field. Fewer bytes than the header gives a truncated packet.
  task automatic queue_packet(input logic [3:0] ver, input logic [3:0] ihl,
                              input logic [7:0] ttl, input logic [31:0] dst,
                              input int n_bytes, input logic [7:0] spoil);
    logic [7:0]  pkt [];
    int          hlen;
    logic [15:0] sum;
    hlen = (ihl < MinHeaderWords) ? MinHeaderBytes : 4 * int'(ihl);
    pkt = new[(n_bytes > hlen) ? n_bytes : hlen];
    foreach (pkt[i]) pkt[i] = 8'($urandom_range(255));
    pkt[0]  = {ver, ihl};
    pkt[TtlPos] = ttl;
    pkt[10] = '0;
    pkt[11] = '0;
    {pkt[16], pkt[17], pkt[18], pkt[19]} = dst;
    sum = '0;
    for (int i = 0; i + 1 < hlen; i += 2) sum = fold_add(sum, {pkt[i], pkt[i + 1]});
    {pkt[10], pkt[11]} = ~sum;
    pkt[10] ^= spoil;
    for (int i = 0; i < n_bytes; i++) bytes_to_send.push_back({i == n_bytes - 1, pkt[i]});
    bytes_queued += n_bytes;
  endtask

  task automatic queue_random_packet();
    int          roll;
    logic [31:0] dst;
    logic [3:0]  ihl;
    int          hlen;
    roll = $urandom_range(99);
    case ($urandom_range(5))
      0, 1, 2: dst = local_addr_q;
      3:       dst = BroadcastAddr;
      default: dst = $urandom;
    endcase
    ihl  = ($urandom_range(9) == 0) ? 4'($urandom_range(6, 15)) : MinHeaderWords;
    hlen = 4 * int'(ihl);
    if (roll < 70) begin
      queue_packet(IpVersion, ihl, 8'($urandom_range(1, 255)), dst,
                   hlen + $urandom_range(4), 8'd0);
    end else if (roll < 88) begin
      case ($urandom_range(4))
        0: queue_packet(IpVersion, ihl, 8'd0, dst, hlen, 8'd0);
        1: queue_packet(4'($urandom_range(15)), ihl, 8'd9, dst, hlen, 8'd0);
        2: queue_packet(IpVersion, 4'($urandom_range(4)), 8'd9, dst,
                        MinHeaderBytes + $urandom_range(4), 8'd0);
        3: queue_packet(IpVersion, ihl, 8'd9, dst, hlen, 8'($urandom_range(1, 255)));
        default: queue_packet(IpVersion, ihl, 8'd9, dst, $urandom_range(1, hlen - 1), 8'd0);
      endcase
    end else begin
      queue_packet(4'($urandom_range(15)), 4'($urandom_range(15)), 8'($urandom_range(255)),
                   $urandom, $urandom_range(1, 30), 8'($urandom_range(255)));
    end
  endtask

  // Lets the block go idle: every byte taken, every verdict back, a few spare cycles.
  task automatic wait_idle();
    while (bytes_to_send.size() != 0 || s_axis_tvalid || verdicts_due.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_local_addr(input logic [31:0] addr);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= addr;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i  <= 1'b0;
    local_addr_q = addr;
  endtask

  // Byte driver: a byte stays on the bus until taken, and idles only between bytes.
  always @(posedge clk_i) begin : drive_bytes
    logic [8:0] item;
    verdict_t   v;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (absorb_byte(s_axis_tdata, s_axis_tlast, v)) verdicts_due.push_back(v);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (bytes_to_send.size() != 0 && (quiet || $urandom_range(99) >= 8)) begin
          item = bytes_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= item[7:0];
          s_axis_tlast  <= item[8];
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Verdict checker, which also paces the output ready with its own long holds.
  always @(posedge clk_i) begin : check_verdicts
    verdict_t    want;
    logic [2:0]  got_status;
    logic [15:0] got_bytes;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_status = m_axis_tdata[2:0];
        got_bytes  = m_axis_tdata[18:3];
        verdicts_seen++;
        if (verdicts_due.size() == 0) begin
          flag_error($sformatf("unexpected verdict status=%0d bytes=%0d",
                               got_status, got_bytes));
        end else begin
          want = verdicts_due.pop_front();
          if (got_status != want.status)
            flag_error($sformatf("verdict %0d: status expected %0d, got %0d",
                                 verdicts_seen, want.status, got_status));
          if (got_bytes != want.packet_bytes)
            flag_error($sformatf("verdict %0d: packet_bytes expected %0d, got %0d",
                                 verdicts_seen, want.packet_bytes, got_bytes));
        end
        // Both holds land inside a random batch, so a held verdict backs up the byte input while they last.
        if (verdicts_seen == 20 || verdicts_seen == 28) holdoff_left = HoldCycles;
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 8);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("ipv4_header_validator_unit test failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [31:0] addr;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The address register comes out of reset as zero.
    queue_packet(IpVersion, MinHeaderWords, 8'd9, 32'd0, 20, 8'd0);
    queue_packet(IpVersion, MinHeaderWords, 8'd9, 32'h0A00_0001, 20, 8'd0);
    wait_idle();

    addr = $urandom;
    write_local_addr(addr);
    queue_packet(4'hF, 4'hF, 8'hFF, BroadcastAddr, 1, 8'd0);
    queue_packet(IpVersion, MinHeaderWords, 8'd64, addr, 19, 8'd0);
    queue_packet(IpVersion, MinHeaderWords, 8'd64, addr, 20, 8'd0);
    queue_packet(IpVersion, MinHeaderWords, 8'hFF, BroadcastAddr, 20, 8'd0);
    queue_packet(IpVersion, MinHeaderWords, 8'd0, addr, 20, 8'd0);
    queue_packet(4'hF, MinHeaderWords, 8'd1, addr, 20, 8'd0);
    queue_packet(IpVersion, 4'd4, 8'd1, addr, 20, 8'd0);
    queue_packet(IpVersion, 4'd0, 8'd1, addr, 24, 8'd0);
    queue_packet(IpVersion, MinHeaderWords, 8'd1, addr ^ 32'h8000_0001, 20, 8'd0);
    queue_packet(IpVersion, MinHeaderWords, 8'd1, addr, 20, 8'h01);
    queue_packet(IpVersion, 4'hF, 8'd200, addr, 64, 8'd0);
    queue_packet(IpVersion, 4'hF, 8'd200, addr, 59, 8'd0);
    // An all-zero header sums to zero; the TTL check fires first.
    for (int i = 0; i < 20; i++) bytes_to_send.push_back({i == 19, 8'h00});
    wait_idle();

    write_local_addr(BroadcastAddr);
    repeat (8) queue_random_packet();
    wait_idle();

    write_local_addr(32'd0);
    quiet <= 1'b1;
    repeat (8) queue_random_packet();
    wait_idle();

    write_local_addr($urandom);
    quiet <= 1'b0;
    while (bytes_queued < 850) queue_random_packet();
    wait_idle();

    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && verdicts_due.size() == 0) begin
      $display("ipv4_header_validator_unit test passed");
    end else begin
      $display("ipv4_header_validator_unit test failed");
    end
    $finish;
  end

endmodule
